// ===== rtl/tbrl_pkg.sv =====
// Package for the token bucket rate limiter: widths, codes, constants and shared types.
`default_nettype none

package tbrl_pkg;

    // Field widths
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIFF_W   = 31;
    localparam int unsigned DQ_W     = 22;
    localparam int unsigned Q_W      = 23;
    localparam int unsigned REM_W    = 10;
    localparam int unsigned TICK_W   = 25;
    localparam int unsigned STEP_W   = 54;

    // Request kinds on the input channel
    localparam logic [KIND_W-1:0] REQ_TICK = 2'd0;
    localparam logic [KIND_W-1:0] REQ_TIME = 2'd1;
    localparam logic [KIND_W-1:0] REQ_USE  = 2'd2;

    // Operations decided at the first stage
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ADD  = 2'd2;
    localparam logic [1:0] OP_USE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET = 2'd1;

    // Division by 1000 and by 250 through one reciprocal, exact for 32-bit operands
    localparam int unsigned MS_PER_SEC  = 1000;
    localparam int unsigned RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd274877907;
    localparam int unsigned SHIFT_MS    = 38;
    localparam int unsigned SHIFT_TICK  = 36;

    // Item travelling down the step pipeline
    typedef struct packed {
        logic [1:0]        op;
        logic [WORD_W-1:0] req;
        logic [DIFF_W-1:0] diff;
    } t_item;

    // Rate and the values derived from it
    typedef struct packed {
        logic [WORD_W-1:0] rate;
        logic [Q_W-1:0]    q;
        logic [REM_W-1:0]  rem;
        logic [TICK_W-1:0] tick;
    } t_rate_cfg;

endpackage

`default_nettype wire

// ===== rtl/tbrl_if.sv =====
// Channel interfaces of the token bucket rate limiter: request, result and configuration.
`default_nettype none

interface tbrl_in_if import tbrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [WORD_W-1:0] now_ms;
    logic [WORD_W-1:0] token_request;

    modport source (output valid, output req_type, output now_ms, output token_request,
                    input ready);
    modport sink   (input valid, input req_type, input now_ms, input token_request,
                    output ready);
endinterface

interface tbrl_out_if import tbrl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              granted;
    logic [WORD_W-1:0] tokens_held;

    modport source (output valid, output granted, output tokens_held, input ready);
    modport sink   (input valid, input granted, input tokens_held, output ready);
endinterface

interface tbrl_cfg_if import tbrl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tbrl_step_pipe.sv =====
// Refill step pipeline: turns elapsed milliseconds and rate into a token step, or passes the tick step for a tick.
`default_nettype none

module tbrl_step_pipe import tbrl_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_item             i_item,
    input  wire t_rate_cfg         i_cfg,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_item                  o_item,
    output logic [STEP_W-1:0]      o_step
);

    // Stage valids and ready chain
    logic r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

    assign rdy7 = !r_v7 || i_ready;
    assign rdy6 = !r_v6 || rdy7;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign o_ready = rdy2;
    assign o_valid = r_v7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            if (rdy2) r_v2 <= i_valid;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
            if (rdy7) r_v7 <= r_v6;
        end
    end

    // Stage payloads
    t_item                  r_it2, r_it3, r_it4, r_it5, r_it6, r_it7;
    logic [DQ_W-1:0]        r_dq3;
    logic [REM_W-1:0]       r_dr4;
    logic [STEP_W-1:0]      r_pa4, r_pa5, r_pab6;
    logic [Q_W+REM_W-1:0]   r_pb5;
    logic [2*REM_W-1:0]     r_pc5;
    logic [REM_W-1:0]       r_pd6;
    logic [STEP_W-1:0]      r_step7;

    // Stage 2: whole seconds of elapsed time
    logic [DIFF_W+RECIP_W-1:0] dq_prod;
    logic [DQ_W-1:0]           n_dq;
    assign dq_prod = (DIFF_W+RECIP_W)'(r_it2.diff) * (DIFF_W+RECIP_W)'(RECIP_MUL);
    assign n_dq    = DQ_W'(dq_prod >> SHIFT_MS);

    // Stage 3: leftover milliseconds, whole seconds times rate
    logic [WORD_W-1:0] dr_full;
    logic [REM_W-1:0]  n_dr;
    logic [STEP_W-1:0] n_pa;
    assign dr_full = WORD_W'(r_it3.diff) - WORD_W'(r_dq3) * WORD_W'(MS_PER_SEC);
    assign n_dr    = dr_full[REM_W-1:0];
    assign n_pa    = STEP_W'(r_dq3) * STEP_W'(i_cfg.rate);

    // Stage 4: leftover milliseconds against rate split into q and remainder
    logic [Q_W+REM_W-1:0] n_pb;
    logic [2*REM_W-1:0]   n_pc;
    assign n_pb = (Q_W+REM_W)'(r_dr4) * (Q_W+REM_W)'(i_cfg.q);
    assign n_pc = (2*REM_W)'(r_dr4) * (2*REM_W)'(i_cfg.rem);

    // Stage 5: fold the small product by 1000, add the two large terms
    logic [2*REM_W+RECIP_W-1:0] pd_prod;
    logic [REM_W-1:0]           n_pd;
    logic [STEP_W-1:0]          n_pab;
    assign pd_prod = (2*REM_W+RECIP_W)'(r_pc5) * (2*REM_W+RECIP_W)'(RECIP_MUL);
    assign n_pd    = REM_W'(pd_prod >> SHIFT_MS);
    assign n_pab   = r_pa5 + STEP_W'(r_pb5);

    // Stage 6: pick the tick step or the finished refill step
    logic [STEP_W-1:0] n_step;
    assign n_step = (r_it6.op == OP_TICK) ? STEP_W'(i_cfg.tick) : (r_pab6 + STEP_W'(r_pd6));

    always_ff @(posedge i_clk) begin
        if (rdy2) r_it2 <= i_item;
        if (rdy3) begin
            r_it3 <= r_it2;
            r_dq3 <= n_dq;
        end
        if (rdy4) begin
            r_it4 <= r_it3;
            r_dr4 <= n_dr;
            r_pa4 <= n_pa;
        end
        if (rdy5) begin
            r_it5 <= r_it4;
            r_pa5 <= r_pa4;
            r_pb5 <= n_pb;
            r_pc5 <= n_pc;
        end
        if (rdy6) begin
            r_it6  <= r_it5;
            r_pab6 <= n_pab;
            r_pd6  <= n_pd;
        end
        if (rdy7) begin
            r_it7   <= r_it6;
            r_step7 <= n_step;
        end
    end

    assign o_item = r_it7;
    assign o_step = r_step7;

    // Quotient by 1000 never overshoots the elapsed time
    a_dq_not_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (WORD_W'(r_dq3) * WORD_W'(MS_PER_SEC) <= WORD_W'(r_it3.diff)))
        else $error("seconds quotient too large");

    // Leftover milliseconds stay below one second
    a_dr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_dr4 < REM_W'(MS_PER_SEC)))
        else $error("leftover milliseconds out of range");

    // A stalled entry stage keeps its word
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !rdy2) |=> (r_v2 && $stable(r_it2)))
        else $error("stage two lost its word under stall");

endmodule

`default_nettype wire

// ===== rtl/token_bucket_rate_limiter_top.sv =====
// Top level of the token bucket rate limiter: timestamp stage, step pipeline, level update.
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    req_type[1:0], now_ms[31:0], token_request[31:0]
//  o_out    out  valid/ready    granted, tokens_held[31:0]
//  i_cfg    in   valid/ready    index[1:0], data[31:0]   (ready always high)
//
// One word is accepted per cycle while the output is not stalled; each result passes through
// the input register, the six-stage step pipeline (two reciprocal multiplies in series) and
// the result register.
// Synchronous active-low reset clears rate, bucket size, level and timestamp state.
// A stalled output holds back stage by stage; empty stages still take new words.
`default_nettype none

module token_bucket_rate_limiter_top import tbrl_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tbrl_in_if.sink     i_in,
    tbrl_out_if.source  o_out,
    tbrl_cfg_if.sink    i_cfg
);

    // Configuration registers and derived rate values
    logic [WORD_W-1:0] r_rate, r_bucket;
    logic [Q_W-1:0]    r_q;
    logic [REM_W-1:0]  r_rem;
    logic [TICK_W-1:0] r_tick;

    logic [WORD_W+RECIP_W-1:0] rate_prod;
    logic [WORD_W-1:0]         rate_left;
    assign rate_prod = (WORD_W+RECIP_W)'(r_rate) * (WORD_W+RECIP_W)'(RECIP_MUL);
    assign rate_left = r_rate - WORD_W'(r_q) * WORD_W'(MS_PER_SEC);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= '0;
            r_bucket <= '0;
            r_q      <= '0;
            r_rem    <= '0;
            r_tick   <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_RATE:   r_rate   <= i_cfg.data;
                    CFG_BUCKET: r_bucket <= i_cfg.data;
                    default: ;
                endcase
            end
            // Quotient and tick step follow the rate, remainder the registered quotient
            r_q    <= Q_W'(rate_prod >> SHIFT_MS);
            r_tick <= TICK_W'(rate_prod >> SHIFT_TICK);
            r_rem  <= rate_left[REM_W-1:0];
        end
    end

    t_rate_cfg rate_cfg;
    assign rate_cfg = '{rate: r_rate, q: r_q, rem: r_rem, tick: r_tick};

    // Input register and timestamp state
    logic              r_s1_valid;
    logic [KIND_W-1:0] r_s1_kind;
    logic [WORD_W-1:0] r_s1_now, r_s1_req;
    logic [WORD_W-1:0] r_last;
    logic              r_seen;

    logic pipe_in_ready, s1_ready, s1_adv;
    assign s1_ready   = !r_s1_valid || pipe_in_ready;
    assign s1_adv     = r_s1_valid && pipe_in_ready;
    assign i_in.ready = s1_ready;

    // Decide the operation from the request kind and, for a time request, the elapsed time
    logic [WORD_W-1:0] diff;
    logic              fire;
    logic [1:0]        s1_op;
    assign diff = r_s1_now - r_last;
    assign fire = r_seen && (diff != '0) && !diff[WORD_W-1];

    always_comb begin
        case (r_s1_kind)
            REQ_TICK: s1_op = OP_TICK;
            REQ_TIME: s1_op = fire ? OP_ADD : OP_NONE;
            REQ_USE:  s1_op = OP_USE;
            default:  s1_op = OP_NONE;
        endcase
    end

    t_item s1_item;
    assign s1_item = '{op: s1_op, req: r_s1_req, diff: diff[DIFF_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_last     <= '0;
            r_seen     <= 1'b0;
        end else begin
            if (s1_ready) r_s1_valid <= i_in.valid;
            // Record the first timestamp, then advance on every refill that counts
            if (s1_adv && (r_s1_kind == REQ_TIME)) begin
                if (!r_seen) begin
                    r_last <= r_s1_now;
                    r_seen <= 1'b1;
                end else if (fire) begin
                    r_last <= r_s1_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_kind <= i_in.req_type;
            r_s1_now  <= i_in.now_ms;
            r_s1_req  <= i_in.token_request;
        end
    end

    // Step pipeline
    logic              pipe_valid;
    logic              out_ready;
    t_item             pipe_item;
    logic [STEP_W-1:0] pipe_step;

    tbrl_step_pipe u_step_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (pipe_in_ready),
        .i_item  (s1_item),
        .i_cfg   (rate_cfg),
        .o_valid (pipe_valid),
        .i_ready (out_ready),
        .o_item  (pipe_item),
        .o_step  (pipe_step)
    );

    // Level update into the result register
    logic [WORD_W-1:0]   r_level;
    logic                r_out_valid, r_out_grant;
    logic [1:0]          r_out_op;
    logic [STEP_W:0]     step_sum;
    logic [WORD_W-1:0]   n_level;
    logic                n_grant;

    assign out_ready = !r_out_valid || o_out.ready;
    assign step_sum  = (STEP_W+1)'(r_level) + (STEP_W+1)'(pipe_step);

    always_comb begin
        n_level = r_level;
        n_grant = 1'b0;
        case (pipe_item.op)
            OP_TICK, OP_ADD: begin
                if (step_sum > (STEP_W+1)'(r_bucket)) n_level = r_bucket;
                else                                  n_level = step_sum[WORD_W-1:0];
            end
            OP_USE: begin
                if (r_level > pipe_item.req) begin
                    n_level = r_level - pipe_item.req;
                    n_grant = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_level     <= '0;
        end else begin
            if (out_ready) r_out_valid <= pipe_valid;
            if (out_ready && pipe_valid) r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && pipe_valid) begin
            r_out_grant <= n_grant;
            r_out_op    <= pipe_item.op;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.granted     = r_out_grant;
    assign o_out.tokens_held = r_level;

    // A refill result never reports more than the bucket holds
    a_refill_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_op == OP_TICK || r_out_op == OP_ADD))
            |-> (o_out.tokens_held <= r_bucket))
        else $error("refill result above bucket size");

    // Only a use request can be granted
    a_grant_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_grant) |-> (r_out_op == OP_USE))
        else $error("grant on a non-use word");

    // Once a timestamp is recorded it stays recorded
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("timestamp flag dropped");

    // A counted refill moves the last refill time to its timestamp
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && (s1_op == OP_ADD)) |=> (r_last == $past(r_s1_now)))
        else $error("last refill time not advanced");

endmodule

`default_nettype wire

// ===== test/token_bucket_checker.sv =====
// Checker for the token bucket rate limiter: tracks the bucket, predicts each result word and compares.
`default_nettype none

module token_bucket_checker import tbrl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tbrl_in_if        i_in,
    tbrl_out_if       i_out,
    tbrl_cfg_if       i_cfg,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TICKS_PER_SEC = 250;
    localparam int          MAX_REPORTS   = 10;

    typedef struct packed {
        logic              granted;
        logic [WORD_W-1:0] tokens_held;
    } t_result;

    // Shadow copy of the block's registers and bucket state
    logic [WORD_W-1:0] rate_limit;
    logic [WORD_W-1:0] bucket_size;
    logic [WORD_W-1:0] token_level;
    logic [WORD_W-1:0] last_refill_ms;
    logic              time_seen;

    t_result expected_results[$];
    int      fail_count;

    // Add tokens, clipping at the bucket size
    function automatic void refill_bucket(input logic [63:0] step);
        logic [63:0] sum;
        sum = {32'd0, token_level} + step;
        if (sum > {32'd0, bucket_size}) begin
            token_level = bucket_size;
        end else begin
            token_level = sum[WORD_W-1:0];
        end
    endfunction

    // Advance the bucket by one request word and return the result it gives
    function automatic t_result bucket_result(input logic [KIND_W-1:0] kind,
                                              input logic [WORD_W-1:0] now_ms,
                                              input logic [WORD_W-1:0] request);
        t_result           res;
        logic [WORD_W-1:0] elapsed;
        logic [63:0]       step;
        res.granted = 1'b0;
        case (kind)
            REQ_TICK: begin
                refill_bucket({32'd0, rate_limit} / 64'(TICKS_PER_SEC));
            end
            REQ_TIME: begin
                if (!time_seen) begin
                    last_refill_ms = now_ms;
                    time_seen      = 1'b1;
                end else begin
                    elapsed = now_ms - last_refill_ms;
                    // only a positive signed elapsed time refills
                    if (elapsed != '0 && !elapsed[WORD_W-1]) begin
                        step = ({32'd0, elapsed} * {32'd0, rate_limit}) / 64'(MS_PER_SEC);
                        last_refill_ms = now_ms;
                        refill_bucket(step);
                    end
                end
            end
            REQ_USE: begin
                if (token_level > request) begin
                    token_level = token_level - request;
                    res.granted = 1'b1;
                end
            end
            default: ;
        endcase
        res.tokens_held = token_level;
        return res;
    endfunction

    // Watch the three channels; compare results before taking new requests
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            rate_limit     = '0;
            bucket_size    = '0;
            token_level    = '0;
            last_refill_ms = '0;
            time_seen      = 1'b0;
            fail_count     = 0;
            expected_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_RATE) begin
                    rate_limit = i_cfg.data;
                end else if (i_cfg.index == CFG_BUCKET) begin
                    bucket_size = i_cfg.data;
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%0t: unexpected result word: granted %0d tokens_held %0d",
                                 $realtime, i_out.granted, i_out.tokens_held);
                    end
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.granted !== want.granted ||
                        i_out.tokens_held !== want.tokens_held) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("%0t: result mismatch: granted exp %0d got %0d, %s %0d got %0d",
                                     $realtime, want.granted, i_out.granted,
                                     "tokens_held exp", want.tokens_held, i_out.tokens_held);
                        end
                        fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(bucket_result(i_in.req_type, i_in.now_ms,
                                                         i_in.token_request));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

`default_nettype wire

// ===== test/token_bucket_rate_limiter_top_tb.sv =====
// Testbench top for the token bucket rate limiter: clock, reset, stimulus, receiver stalls and verdict.
`default_nettype none

module token_bucket_rate_limiter_top_tb import tbrl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0]    REQ_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    logic i_clk;
    logic i_rst_n;

    tbrl_in_if  in_ch ();
    tbrl_out_if out_ch ();
    tbrl_cfg_if cfg_ch ();

    int fail_count;
    int pending;

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int hold_left;

    logic [WORD_W-1:0] stim_now_ms;

    token_bucket_rate_limiter_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    token_bucket_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up after a generous fixed time
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when asked
    initial begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one request word, with random idle cycles first, and hold it until taken
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [WORD_W-1:0] now_ms,
                                input logic [WORD_W-1:0] request);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= kind;
        in_ch.now_ms        <= now_ms;
        in_ch.token_request <= request;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every expected result word has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_bucket(input logic [WORD_W-1:0] rate, input logic [WORD_W-1:0] size);
        drain_results();
        write_reg(CFG_RATE, rate);
        write_reg(CFG_BUCKET, size);
    endtask

    // One random request word: mostly refills and uses, a few of the spare kind
    task automatic send_random();
        int                sel;
        logic [WORD_W-1:0] request;
        sel = $urandom_range(99);
        if (sel < 30) begin
            send_request(REQ_TICK, $urandom, $urandom);
        end else if (sel < 60) begin
            case ($urandom_range(9))
                7:       stim_now_ms = $urandom;
                8:       stim_now_ms = stim_now_ms - $urandom_range(500);
                9:       ;
                default: stim_now_ms = stim_now_ms + $urandom_range(1, 3000);
            endcase
            send_request(REQ_TIME, stim_now_ms, $urandom);
        end else if (sel < 95) begin
            if ($urandom_range(1) == 0) begin
                request = $urandom_range(4000);
            end else begin
                request = $urandom >> $urandom_range(31);
            end
            send_request(REQ_USE, $urandom, request);
        end else begin
            send_request(REQ_SPARE, $urandom, $urandom);
        end
    endtask

    task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct,
                             input logic [WORD_W-1:0] rate, input logic [WORD_W-1:0] size,
                             input bit with_hold);
        set_bucket(rate, size);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            if (with_hold && i == 20) begin
                hold_req = 1'b1;
            end
            send_random();
        end
    endtask

    // Stimulus and verdict
    initial begin
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_req            = 1'b0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.req_type      <= REQ_TICK;
        in_ch.now_ms        <= '0;
        in_ch.token_request <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_RATE;
        cfg_ch.data         <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty bucket with zero rate: a tick adds nothing, a zero use equals the level
        write_reg(CFG_RATE, '0);
        write_reg(CFG_BUCKET, '0);
        send_request(REQ_TICK, '0, '0);
        send_request(REQ_USE, '0, '0);

        // Writes to spare indexes must leave both registers alone
        set_bucket(32'd250_000, 32'd1_000_000);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '1);
        send_request(REQ_TICK, '0, '0);
        send_request(REQ_USE, '0, 32'd1000);
        send_request(REQ_USE, '0, 32'd999);
        // first timestamp only records, then zero, negative and positive elapsed times
        send_request(REQ_TIME, 32'd100, '0);
        send_request(REQ_TIME, 32'd100, '0);
        send_request(REQ_TIME, 32'd50, '0);
        send_request(REQ_TIME, 32'd1100, '0);
        send_request(REQ_TIME, 32'd1100 + 32'h7FFF_FFFF, '0);
        send_request(REQ_TIME, 32'd1100 + 32'h7FFF_FFFF + 32'h8000_0000, '0);
        send_request(REQ_SPARE, '1, '1);
        send_request(REQ_USE, '1, '1);
        send_request(REQ_USE, '1, '0);
        send_request(REQ_TICK, '1, '1);

        // Lowered bucket clips the level even when the tick step is zero
        set_bucket(32'd100, 32'd10);
        send_request(REQ_TICK, '0, '0);
        send_request(REQ_USE, '0, 32'd9);

        // Largest rate and bucket
        set_bucket('1, '1);
        send_request(REQ_TICK, '0, '0);
        stim_now_ms = 32'd1100 + 32'h7FFF_FFFF + 32'h7FFF_FFFF;
        send_request(REQ_TIME, stim_now_ms, '0);
        send_request(REQ_USE, '0, 32'hFFFF_FFFE);
        send_request(REQ_USE, '0, 32'd1);

        // Random phases, each with its own bucket setting and idling pattern
        run_phase(110, 0, 0, $urandom_range(1000, 5_000_000), $urandom_range(1000, 200_000), 1'b1);
        run_phase(110, 68, 0, 32'd500_000, 32'd4000, 1'b0);
        run_phase(110, 0, 68, $urandom_range(249), $urandom_range(3000), 1'b0);
        run_phase(110, 21, 21, '1, '1, 1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tbrl_pkg.sv
rtl/tbrl_if.sv
rtl/tbrl_step_pipe.sv
rtl/token_bucket_rate_limiter_top.sv
test/token_bucket_checker.sv
test/token_bucket_rate_limiter_top_tb.sv
